// ----- src/pcta_pkg.sv -----
// ----------------------------------------------------------------------------
// pcta_pkg
// shared types and constants of the per-cell temporal aggregator
// ----------------------------------------------------------------------------
package pcta_pkg;

  localparam int unsigned DEF_CELLS = 4096;

  localparam int unsigned VAL_W     = 32;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned STEP_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // average path: product and sum in 49 bits, magnitude in 48 bits
  localparam int unsigned NUM_W     = 49;
  localparam int unsigned DIV_W     = 48;
  localparam int unsigned DEN_W     = STEP_W + 1;
  localparam int unsigned DIV_STEPS = 2;
  localparam int unsigned DIV_ITERS = DIV_W / DIV_STEPS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_ITERS);

  localparam logic [VAL_W-1:0]  NODATA_RST   = 32'hD8F1_0000;
  localparam logic [VAL_W-1:0]  MIN_SEED_RST = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0]  MAX_SEED_RST = 32'h8000_0000;
  localparam logic [VAL_W-1:0]  AGG_MAX      = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0]  AGG_MIN      = 32'h8000_0000;
  localparam logic [STEP_W-1:0] STEP_MAX     = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_AVG = 2'd0,
    MODE_SUM = 2'd1,
    MODE_MIN = 2'd2,
    MODE_MAX = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 2'd0,
    REG_NODATA   = 2'd1,
    REG_MIN_SEED = 2'd2,
    REG_MAX_SEED = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- src/pcta_div.sv -----
// ----------------------------------------------------------------------------
// pcta_div
// iterative unsigned restoring divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
module pcta_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [pcta_pkg::DIV_W-1:0]     dividend_i,
  input  logic [pcta_pkg::DEN_W-1:0]     divisor_i,
  output logic [pcta_pkg::DIV_W-1:0]     quotient_o,
  output pcta_pkg::div_stat_t            stat_o
);
  import pcta_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0]     den_q, rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;

  always_comb begin
    logic [DEN_W:0] r_ext;
    rem_d = rem_q;
    quo_d = quo_q;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r_ext = {rem_d, quo_d[DIV_W-1]};
      quo_d = {quo_d[DIV_W-2:0], 1'b0};
      if (r_ext >= {1'b0, den_q}) begin
        r_ext    = r_ext - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end
      rem_d = r_ext[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_ITERS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ----- src/pcta_cells.sv -----
// ----------------------------------------------------------------------------
// pcta_cells
// per-cell aggregate memory and valid-bit memory with clearing sweep
// ----------------------------------------------------------------------------
module pcta_cells #(
  parameter int unsigned CELLS = pcta_pkg::DEF_CELLS,
  parameter int unsigned AW    = $clog2(CELLS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pcta_pkg::mem_ctrl_t         ctrl_i,
  input  logic [AW-1:0]               addr_i,
  input  logic [pcta_pkg::VAL_W-1:0]  wdata_i,
  output logic [pcta_pkg::VAL_W-1:0]  rdata_o,
  output logic                        rvalid_o,
  output logic                        clearing_o
);
  import pcta_pkg::*;

  logic [VAL_W-1:0] agg_mem [CELLS];
  logic             valid_mem [CELLS];

  logic [AW-1:0]    clr_q;
  logic             clr_busy_q;
  logic [VAL_W-1:0] rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == AW'(CELLS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      valid_mem[clr_q] <= 1'b0;
    end else if (ctrl_i.wr) begin
      valid_mem[addr_i] <= 1'b1;
    end
    if (ctrl_i.rd) begin
      rvalid_q <= valid_mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      agg_mem[addr_i] <= wdata_i;
    end
    if (ctrl_i.rd) begin
      rdata_q <= agg_mem[addr_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign rvalid_o   = rvalid_q;
  assign clearing_o = clr_busy_q;

endmodule

// ----- src/per_cell_temporal_aggregator_top.sv -----
// ----------------------------------------------------------------------------
// per_cell_temporal_aggregator_top
// per-cell running average, saturating sum, minimum or maximum of Q16.16
// raster samples, with a saturating time-step counter
// ----------------------------------------------------------------------------
// After reset the valid bits of all CELLS cells are swept clear, one cell per
// cycle, and no sample is taken until the sweep is done; configuration
// writes are taken at any time. The block works on one sample at a time and
// is not ready while it does. A sample in sum, minimum or maximum mode, a
// nodata sample or an index of CELLS or more goes from transfer to result
// in steps: memory read, update, write back. In average mode the update is a
// multiply, an add and a magnitude step, then the divider resolves the 48-bit
// dividend two quotient bits per cycle, then the write back. The result
// register lets the next sample in while a result waits.
module per_cell_temporal_aggregator_top #(
  parameter int unsigned CELLS = pcta_pkg::DEF_CELLS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pcta_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pcta_pkg::VAL_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [pcta_pkg::IDX_W-1:0]         cell_index_i,
  input  logic signed [pcta_pkg::VAL_W-1:0]  cell_value_i,
  input  logic                               end_of_step_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [pcta_pkg::IDX_W-1:0]         out_index_o,
  output logic signed [pcta_pkg::VAL_W-1:0]  aggregate_o,
  output logic                               cell_empty_o,
  output logic [pcta_pkg::STEP_W-1:0]        steps_done_o
);
  import pcta_pkg::*;

  localparam int unsigned AW = $clog2(CELLS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ADD,
    S_ABS,
    S_DIV,
    S_FIN
  } state_e;

  state_e            state_q;
  mode_e             mode_q;
  logic [VAL_W-1:0]  nodata_q, min_seed_q, max_seed_q;
  logic [STEP_W-1:0] step_q;

  logic [IDX_W-1:0]  idx_q;
  logic [VAL_W-1:0]  x_q;
  logic              eos_q, inr_q, upd_q, empty_q, neg_q;
  logic [VAL_W-1:0]  res_q;
  logic [NUM_W-1:0]  prod_q, num_q;

  logic              out_valid_q, cell_empty_q;
  logic [IDX_W-1:0]  out_index_q;
  logic [VAL_W-1:0]  aggregate_q;
  logic [STEP_W-1:0] steps_done_q;

  mem_ctrl_t         mem_ctrl;
  logic [AW-1:0]     mem_addr;
  logic [VAL_W-1:0]  rd_agg;
  logic              rd_valid, clearing;

  div_stat_t         div_st;
  logic              div_start;
  logic [DIV_W-1:0]  div_dividend, div_quo;
  logic [DEN_W-1:0]  div_divisor;
  logic [NUM_W-1:0]  num_neg;

  logic              in_xfer, fin_go, in_range;
  logic [VAL_W-1:0]  old_val, sum_val, div_val, nv_mm;
  logic [VAL_W:0]    sum_ext;
  logic [STEP_W-1:0] step_next;

  // ---------------------------------------------------------------- datapath
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE) && !clearing;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign fin_go      = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign in_range    = 32'(cell_index_i) < 32'(CELLS);

  assign mem_ctrl.rd = in_xfer;
  assign mem_ctrl.wr = fin_go && upd_q;
  assign mem_addr    = (state_q == S_IDLE) ? AW'(cell_index_i) : AW'(idx_q);

  always_comb begin
    if (rd_valid) begin
      old_val = rd_agg;
    end else begin
      unique case (mode_q)
        MODE_MIN: old_val = min_seed_q;
        MODE_MAX: old_val = max_seed_q;
        default:  old_val = '0;
      endcase
    end
  end

  assign sum_ext = {old_val[VAL_W-1], old_val} + {x_q[VAL_W-1], x_q};
  always_comb begin
    if (sum_ext[VAL_W] != sum_ext[VAL_W-1]) begin
      sum_val = sum_ext[VAL_W] ? AGG_MIN : AGG_MAX;
    end else begin
      sum_val = sum_ext[VAL_W-1:0];
    end
  end

  always_comb begin
    if (mode_q == MODE_MIN) begin
      nv_mm = ($signed(x_q) <= $signed(old_val)) ? x_q : old_val;
    end else begin
      nv_mm = ($signed(x_q) >= $signed(old_val)) ? x_q : old_val;
    end
  end

  // truncating signed division as magnitude division and sign fix
  assign num_neg      = -num_q;
  assign div_start    = (state_q == S_ABS);
  assign div_dividend = num_q[NUM_W-1] ? num_neg[DIV_W-1:0] : num_q[DIV_W-1:0];
  assign div_divisor  = DEN_W'(step_q) + 1'b1;

  always_comb begin
    if (!neg_q) begin
      div_val = (div_quo > DIV_W'(AGG_MAX)) ? AGG_MAX : div_quo[VAL_W-1:0];
    end else begin
      div_val = (div_quo > DIV_W'(AGG_MIN)) ? AGG_MIN : -div_quo[VAL_W-1:0];
    end
  end

  assign step_next = (eos_q && step_q != STEP_MAX) ? step_q + 1'b1 : step_q;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_AVG;
      nodata_q   <= NODATA_RST;
      min_seed_q <= MIN_SEED_RST;
      max_seed_q <= MAX_SEED_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MODE:     mode_q     <= mode_e'(cfg_data_i[1:0]);
        REG_NODATA:   nodata_q   <= cfg_data_i;
        REG_MIN_SEED: min_seed_q <= cfg_data_i;
        REG_MAX_SEED: max_seed_q <= cfg_data_i;
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      upd_q       <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (!inr_q) begin
            upd_q   <= 1'b0;
            state_q <= S_FIN;
          end else if (x_q == nodata_q) begin
            upd_q   <= 1'b0;
            state_q <= S_FIN;
          end else begin
            upd_q   <= 1'b1;
            state_q <= (mode_q == MODE_AVG) ? S_ADD : S_FIN;
          end
        end
        S_ADD: begin
          state_q <= S_ABS;
        end
        S_ABS: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_st.done) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            step_q      <= step_next;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      idx_q <= cell_index_i;
      x_q   <= cell_value_i;
      eos_q <= end_of_step_i;
      inr_q <= in_range;
    end
    if (state_q == S_LOAD) begin
      if (!inr_q) begin
        res_q   <= nodata_q;
        empty_q <= 1'b1;
      end else if (x_q == nodata_q) begin
        res_q   <= rd_valid ? rd_agg : nodata_q;
        empty_q <= !rd_valid;
      end else begin
        empty_q <= 1'b0;
        unique case (mode_q)
          MODE_AVG: prod_q <= NUM_W'($signed(old_val) * $signed({1'b0, step_q}));
          MODE_SUM: res_q  <= sum_val;
          MODE_MIN: res_q  <= nv_mm;
          MODE_MAX: res_q  <= nv_mm;
        endcase
      end
    end
    if (state_q == S_ADD) begin
      num_q <= prod_q + {{(NUM_W - VAL_W){x_q[VAL_W-1]}}, x_q};
    end
    if (state_q == S_ABS) begin
      neg_q <= num_q[NUM_W-1];
    end
    if (state_q == S_DIV && div_st.done) begin
      res_q <= div_val;
    end
    if (fin_go) begin
      out_index_q  <= idx_q;
      aggregate_q  <= res_q;
      cell_empty_q <= empty_q;
      steps_done_q <= step_next;
    end
  end

  // ---------------------------------------------------------------- units
  pcta_cells #(
    .CELLS (CELLS),
    .AW    (AW)
  ) u_cells (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mem_ctrl),
    .addr_i     (mem_addr),
    .wdata_i    (res_q),
    .rdata_o    (rd_agg),
    .rvalid_o   (rd_valid),
    .clearing_o (clearing)
  );

  pcta_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .stat_o     (div_st)
  );

  assign out_valid_o  = out_valid_q;
  assign out_index_o  = out_index_q;
  assign aggregate_o  = aggregate_q;
  assign cell_empty_o = cell_empty_q;
  assign steps_done_o = steps_done_q;

  // ---------------------------------------------------------------- checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_LOAD)
    else $error("accepted sample did not start a cell read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctrl.wr |-> upd_q && inr_q && x_q != nodata_q)
    else $error("cell written by a nodata or out-of-range sample");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> step_q >= $past(step_q))
    else $error("time-step counter went backward");

endmodule

// ----- dv/per_cell_temporal_aggregator_top_tb.sv -----
// ----------------------------------------------------------------------------
// per_cell_temporal_aggregator_top_tb
// self-checking bench for the per-cell temporal aggregator: a queue-fed
// driver sends cell samples, a monitor compares every result against an
// in-bench model of the per-cell aggregates, valid bits and step counter
// across all modes, nodata and seed settings
// ----------------------------------------------------------------------------
module per_cell_temporal_aggregator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcta_pkg::*;

  localparam int unsigned CELLS          = DEF_CELLS;
  localparam int          WATCHDOG_LIMIT = 20000;
  localparam int          SETTLE_CYCLES  = 40;
  localparam int          RANDOM_PHASES  = 12;
  localparam int          PHASE_ITEMS    = 31;
  localparam longint      AGG_HI         = 64'sd2147483647;
  localparam longint      AGG_LO         = -64'sd2147483648;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
    logic             eos;
  } sample_t;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  agg;
    logic              empty;
    logic [STEP_W-1:0] steps;
  } cell_result_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i   = '0;
  logic [VAL_W-1:0]         cfg_data_i    = '0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_ready_o;
  logic [IDX_W-1:0]         cell_index_i  = '0;
  logic signed [VAL_W-1:0]  cell_value_i  = '0;
  logic                     end_of_step_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i   = 1'b0;
  logic [IDX_W-1:0]         out_index_o;
  logic signed [VAL_W-1:0]  aggregate_o;
  logic                     cell_empty_o;
  logic [STEP_W-1:0]        steps_done_o;

  per_cell_temporal_aggregator_top #(
    .CELLS(CELLS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cell_index_i (cell_index_i),
    .cell_value_i (cell_value_i),
    .end_of_step_i(end_of_step_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_index_o  (out_index_o),
    .aggregate_o  (aggregate_o),
    .cell_empty_o (cell_empty_o),
    .steps_done_o (steps_done_o)
  );

  // model state and register copies
  logic [VAL_W-1:0]  cell_agg [CELLS];
  bit                cell_valid [CELLS];
  logic [STEP_W-1:0] step_cnt   = '0;
  mode_e             cur_mode   = MODE_AVG;
  logic [VAL_W-1:0]  nodata_q   = NODATA_RST;
  logic [VAL_W-1:0]  min_seed_q = MIN_SEED_RST;
  logic [VAL_W-1:0]  max_seed_q = MAX_SEED_RST;

  sample_t      sample_q[$];
  cell_result_t pending_results[$];
  sample_t      cur_sample;
  cell_result_t want;
  bit           in_flight   = 1'b0;
  bit           quiet       = 1'b0;
  int           in_gap      = 0;
  int           out_stall   = 0;
  int           err_count   = 0;
  int           idle_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic cell_result_t predict_update(sample_t s);
    cell_result_t r;
    longint       x_v;
    longint       old_v;
    longint       n_v;
    longint       nv;
    r.idx   = s.idx;
    r.agg   = nodata_q;
    r.empty = 1'b1;
    if (s.idx < CELLS) begin
      if (s.value != nodata_q) begin
        x_v = longint'($signed(s.value));
        if (cell_valid[s.idx]) old_v = longint'($signed(cell_agg[s.idx]));
        else if (cur_mode == MODE_MIN) old_v = longint'($signed(min_seed_q));
        else if (cur_mode == MODE_MAX) old_v = longint'($signed(max_seed_q));
        else old_v = 0;
        case (cur_mode)
          MODE_AVG: begin
            n_v = longint'(step_cnt);
            nv  = (old_v * n_v + x_v) / (n_v + 1);
          end
          MODE_SUM: nv = old_v + x_v;
          MODE_MIN: nv = (x_v <= old_v) ? x_v : old_v;
          default:  nv = (x_v >= old_v) ? x_v : old_v;
        endcase
        if (nv > AGG_HI) nv = AGG_HI;
        if (nv < AGG_LO) nv = AGG_LO;
        cell_agg[s.idx]   = nv[VAL_W-1:0];
        cell_valid[s.idx] = 1'b1;
      end
      if (cell_valid[s.idx]) begin
        r.agg   = cell_agg[s.idx];
        r.empty = 1'b0;
      end
    end
    if (s.eos && step_cnt != STEP_MAX) step_cnt++;
    r.steps = step_cnt;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VAL_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return AGG_MAX;
      1:       return AGG_MIN;
      2:       return 32'($urandom_range(0, 8000)) - 32'd4000;
      default: return $urandom();
    endcase
  endfunction

  task automatic push_sample(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] value,
                             input logic eos);
    sample_t s;
    s.idx   = idx;
    s.value = value;
    s.eos   = eos;
    sample_q.push_back(s);
  endtask

  task automatic push_random_sample();
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
    case ($urandom_range(0, 9))
      0:       idx = '0;
      1:       idx = '1;
      2, 3, 4: idx = IDX_W'($urandom_range(0, CELLS - 1));
      default: idx = IDX_W'($urandom_range(0, 15));
    endcase
    case ($urandom_range(0, 9))
      0, 1:    value = nodata_q;
      2:       value = AGG_MAX;
      3:       value = AGG_MIN;
      4:       value = '0;
      5, 6:    value = 32'($urandom_range(0, 2000)) - 32'd1000;
      default: value = $urandom();
    endcase
    push_sample(idx, value, $urandom_range(0, 3) == 0);
  endtask

  task automatic write_reg(input cfg_reg_e r, input logic [VAL_W-1:0] d);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (r)
      REG_MODE:     cur_mode   = mode_e'(d[1:0]);
      REG_NODATA:   nodata_q   = d;
      REG_MIN_SEED: min_seed_q = d;
      default:      max_seed_q = d;
    endcase
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || in_flight || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // sample driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pending_results.push_back(predict_update(cur_sample));
        in_flight = 1'b0;
        in_gap    = pick_gap();
      end
      if (!in_flight) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (sample_q.size() > 0) begin
          cur_sample = sample_q.pop_front();
          in_flight  = 1'b1;
          in_valid_i    <= 1'b1;
          cell_index_i  <= cur_sample.idx;
          cell_value_i  <= cur_sample.value;
          end_of_step_i <= cur_sample.eos;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result for cell %0d", out_index_o);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_index_o !== want.idx) begin
            $error("out_index: expected %0d, got %0d", want.idx, out_index_o);
            err_count++;
          end
          if (aggregate_o !== want.agg) begin
            $error("aggregate: expected %0d, got %0d", $signed(want.agg), aggregate_o);
            err_count++;
          end
          if (cell_empty_o !== want.empty) begin
            $error("cell_empty: expected %0d, got %0d", want.empty, cell_empty_o);
            err_count++;
          end
          if (steps_done_o !== want.steps) begin
            $error("steps_done: expected %0d, got %0d", want.steps, steps_done_o);
            err_count++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_stall = pick_gap();
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset registers, average mode: nodata on an empty cell, extremes, sign of truncation
    push_sample(12'd0, NODATA_RST, 1'b0);
    push_sample(12'd0, AGG_MAX, 1'b0);
    push_sample(12'd4095, AGG_MIN, 1'b1);
    push_sample(12'd0, AGG_MIN, 1'b0);
    push_sample(12'd4095, AGG_MAX, 1'b1);
    push_sample(12'd1, 32'hFFFF_FFFD, 1'b0);
    push_sample(12'd1, 32'h0001_0000, 1'b1);
    wait_idle();

    // sum mode, saturation both ways, zero as nodata
    write_reg(REG_MODE, {30'h0, MODE_SUM});
    write_reg(REG_NODATA, '0);
    write_reg(REG_MIN_SEED, AGG_MIN);
    write_reg(REG_MAX_SEED, AGG_MAX);
    push_sample(12'd2, '0, 1'b0);
    push_sample(12'd2, AGG_MAX, 1'b0);
    push_sample(12'd2, AGG_MAX, 1'b0);
    push_sample(12'd3, AGG_MIN, 1'b0);
    push_sample(12'd3, AGG_MIN, 1'b1);
    push_sample(12'd0, 32'd5, 1'b0);
    wait_idle();

    // minimum mode with low seed, then high seed
    write_reg(REG_MODE, {30'h0, MODE_MIN});
    write_reg(REG_NODATA, AGG_MAX);
    push_sample(12'd10, 32'd100, 1'b0);
    push_sample(12'd10, AGG_MIN, 1'b0);
    push_sample(12'd0, AGG_MAX, 1'b0);
    wait_idle();
    write_reg(REG_MIN_SEED, AGG_MAX);
    push_sample(12'd11, 32'd7, 1'b1);
    wait_idle();

    // maximum mode with low seed
    write_reg(REG_MODE, {30'h0, MODE_MAX});
    write_reg(REG_NODATA, AGG_MIN);
    write_reg(REG_MAX_SEED, AGG_MIN);
    push_sample(12'd20, 32'hFFFF_FFFB, 1'b0);
    push_sample(12'd20, AGG_MIN, 1'b0);
    push_sample(12'd21, AGG_MAX, 1'b1);
    push_sample(12'd3, AGG_MAX, 1'b0);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(REG_MODE, $urandom());
      if ($urandom_range(0, 1)) write_reg(REG_NODATA, pick_word());
      if ($urandom_range(0, 1)) write_reg(REG_MIN_SEED, pick_word());
      if ($urandom_range(0, 1)) write_reg(REG_MAX_SEED, pick_word());
      quiet = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) push_random_sample();
      wait_idle();
    end

    // average mode on the aggregates left by the random phases
    write_reg(REG_MODE, {30'h0, MODE_AVG});
    quiet = 1'b0;
    repeat (12) push_random_sample();
    wait_idle();

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
